@@ sv/dsrq_pkg.sv @@
package dsrq_pkg;

	localparam int MAX_RESULTS = 64;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);
	localparam logic [30:0] SLEEP_MAX = 31'h7FFF_FFFF;

	localparam logic [1:0] MODE_SCHED = 2'd0;
	localparam logic [1:0] MODE_POLL = 2'd1;
	localparam logic [1:0] MODE_CANCEL = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		ST_QUEUED = 3'd0,
		ST_IGNORED = 3'd1,
		ST_REMOVED = 3'd2,
		ST_EXPIRED = 3'd3,
		ST_NONE = 3'd4
	} dsrq_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UL_RD,
		S_UL_WR,
		S_INS_RD,
		S_INS_CMP,
		S_WALK,
		S_LINK1,
		S_LINK2,
		S_RESULT,
		S_P_RD,
		S_P_CMP,
		S_P_FIX,
		S_E_RD,
		S_E_OUT
	} dsrq_state_t;

	// Write enables of the deadline, forward-link and backward-link stores.
	typedef struct packed {
		logic dl_we;
		logic nx_we;
		logic pv_we;
	} dsrq_wen_t;

endpackage

@@ sv/deadline_sorted_request_queue_top.sv @@
// Channel  | Signals                                     | Transaction
// ---------+---------------------------------------------+------------------------------
// command  | start, busy, mode, slot, delay_us, resync,  | start high while busy low
//          | now_us                                      |
// result   | done, out_slot, status, sleep_us, last      | done high for one cycle
//
// A schedule request compares the head, walks the chain one entry a cycle past entries
// with no later deadline (S_WALK) and links in S_LINK1 and S_LINK2; a resync first
// unlinks the slot. An ignored request goes straight to the result, a cancel unlinks
// first unless the slot is idle. An empty-queue poll goes from S_P_RD to the result;
// otherwise it scans expired entries one a cycle (S_P_CMP), sets the new head (S_P_FIX)
// and reports each entry in S_E_RD and S_E_OUT. The walks are set by the single read
// port of the deadline and link memory. Reset clears the queued flags and the head; the
// memories need no clearing. The receiver cannot stall: every result is shown once with
// done high, and busy stays high until the last result of the transaction.
module deadline_sorted_request_queue_top #(
	parameter int SLOTS = 64,
	parameter int TIME_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] mode,
	input logic [5:0] slot,
	input logic [30:0] delay_us,
	input logic resync,
	input logic [31:0] now_us,
	output logic done,
	output logic [5:0] out_slot,
	output logic [2:0] status,
	output logic [30:0] sleep_us,
	output logic last
);
	import dsrq_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int LW = $clog2(SLOTS + 1);
	localparam logic [LW-1:0] NIL = LW'(SLOTS);

	// Slot numbers fold onto the store; the fold is a constant table over the
	// 64 possible slot codes.
	function automatic logic [IDX_W-1:0] fold_slot(input logic [5:0] x);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = 0; i < 64; i++) begin
			if (6'(i) == x) begin
				r = IDX_W'(i % SLOTS);
			end
		end
		return r;
	endfunction

	function automatic logic [30:0] sat_sleep(input logic [TIME_BITS-1:0] d);
		logic [30:0] r;
		if (64'(d) > 64'(SLEEP_MAX)) begin
			r = SLEEP_MAX;
		end else begin
			r = 31'(d);
		end
		return r;
	endfunction

	dsrq_state_t state_q, state_d;
	logic [SLOTS-1:0] flags_q, flags_d;
	logic [LW-1:0] head_q, head_d;
	logic [IDX_W-1:0] s_q, s_d;
	logic [TIME_BITS-1:0] dl_q, dl_d;
	logic [TIME_BITS-1:0] now_q, now_d;
	logic after_q, after_d;
	logic [LW-1:0] r_q, r_d;
	logic [LW-1:0] n_q, n_d;
	logic [LW-1:0] cur_q, cur_d;
	logic [LW-1:0] oldhead_q, oldhead_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] k_q, k_d;
	logic [30:0] sleep_q, sleep_d;
	dsrq_status_t res_status_q, res_status_d;
	logic [5:0] res_slot_q, res_slot_d;

	dsrq_wen_t wen;
	logic [IDX_W-1:0] a_waddr, a_raddr, b_waddr;
	logic [TIME_BITS-1:0] dl_wdata, dl_rdata;
	logic [LW-1:0] nx_wdata, nx_rdata, pv_wdata, pv_rdata;

	logic [IDX_W-1:0] s_in;
	logic [TIME_BITS-1:0] diff;
	logic expired;

	dsrq_store #(
		.SLOTS(SLOTS),
		.TIME_BITS(TIME_BITS)
	) u_store (
		.clk(clk),
		.wen(wen),
		.a_waddr(a_waddr),
		.dl_wdata(dl_wdata),
		.nx_wdata(nx_wdata),
		.a_raddr(a_raddr),
		.dl_rdata(dl_rdata),
		.nx_rdata(nx_rdata),
		.b_waddr(b_waddr),
		.pv_wdata(pv_wdata),
		.b_raddr(s_q),
		.pv_rdata(pv_rdata)
	);

	assign s_in = fold_slot(slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			flags_q <= '0;
			head_q <= NIL;
		end else begin
			state_q <= state_d;
			flags_q <= flags_d;
			head_q <= head_d;
		end
	end

	always_ff @(posedge clk) begin
		s_q <= s_d;
		dl_q <= dl_d;
		now_q <= now_d;
		after_q <= after_d;
		r_q <= r_d;
		n_q <= n_d;
		cur_q <= cur_d;
		oldhead_q <= oldhead_d;
		cnt_q <= cnt_d;
		k_q <= k_d;
		sleep_q <= sleep_d;
		res_status_q <= res_status_d;
		res_slot_q <= res_slot_d;
	end

	always_comb begin
		state_d = state_q;
		flags_d = flags_q;
		head_d = head_q;
		s_d = s_q;
		dl_d = dl_q;
		now_d = now_q;
		after_d = after_q;
		r_d = r_q;
		n_d = n_q;
		cur_d = cur_q;
		oldhead_d = oldhead_q;
		cnt_d = cnt_q;
		k_d = k_q;
		sleep_d = sleep_q;
		res_status_d = res_status_q;
		res_slot_d = res_slot_q;
		wen = '0;
		a_waddr = s_q;
		a_raddr = IDX_W'(cur_q);
		b_waddr = s_q;
		dl_wdata = dl_q;
		nx_wdata = n_q;
		pv_wdata = r_q;
		diff = '0;
		expired = 1'b0;
		done = 1'b0;
		out_slot = res_slot_q;
		status = res_status_q;
		sleep_us = sleep_q;
		last = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					s_d = s_in;
					now_d = TIME_BITS'(now_us);
					dl_d = TIME_BITS'(now_us) + TIME_BITS'(delay_us);
					res_slot_d = 6'(s_in);
					sleep_d = '0;
					cnt_d = '0;
					unique case (mode)
						MODE_SCHED: begin
							res_status_d = ST_QUEUED;
							after_d = 1'b1;
							if (flags_q[s_in] && !resync) begin
								res_status_d = ST_IGNORED;
								state_d = S_RESULT;
							end else if (flags_q[s_in]) begin
								state_d = S_UL_RD;
							end else begin
								state_d = S_INS_RD;
							end
						end
						MODE_POLL: begin
							state_d = S_P_RD;
						end
						MODE_CANCEL: begin
							res_status_d = ST_REMOVED;
							after_d = 1'b0;
							state_d = flags_q[s_in] ? S_UL_RD : S_RESULT;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_UL_RD: begin
				a_raddr = s_q;
				state_d = S_UL_WR;
			end
			S_UL_WR: begin
				// Neighbors of the slot are joined around it.
				if (pv_rdata != NIL) begin
					wen.nx_we = 1'b1;
					a_waddr = IDX_W'(pv_rdata);
					nx_wdata = nx_rdata;
				end else if (head_q == LW'(s_q)) begin
					head_d = nx_rdata;
				end
				if (nx_rdata != NIL) begin
					wen.pv_we = 1'b1;
					b_waddr = IDX_W'(nx_rdata);
					pv_wdata = pv_rdata;
				end
				flags_d[s_q] = 1'b0;
				state_d = after_q ? S_INS_RD : S_RESULT;
			end
			S_INS_RD: begin
				wen.dl_we = 1'b1;
				a_waddr = s_q;
				dl_wdata = dl_q;
				a_raddr = IDX_W'(head_q);
				state_d = S_INS_CMP;
			end
			S_INS_CMP: begin
				diff = dl_q - dl_rdata;
				if (head_q == NIL || diff[TIME_BITS-1]) begin
					r_d = NIL;
					n_d = head_q;
					state_d = S_LINK1;
				end else begin
					r_d = head_q;
					n_d = nx_rdata;
					a_raddr = IDX_W'(nx_rdata);
					state_d = (nx_rdata == NIL) ? S_LINK1 : S_WALK;
				end
			end
			S_WALK: begin
				// The read data belong to the candidate successor n_q.
				diff = dl_rdata - dl_q;
				if (diff != '0 && !diff[TIME_BITS-1]) begin
					state_d = S_LINK1;
				end else begin
					r_d = n_q;
					n_d = nx_rdata;
					a_raddr = IDX_W'(nx_rdata);
					state_d = (nx_rdata == NIL) ? S_LINK1 : S_WALK;
				end
			end
			S_LINK1: begin
				wen.nx_we = 1'b1;
				a_waddr = s_q;
				nx_wdata = n_q;
				wen.pv_we = 1'b1;
				b_waddr = s_q;
				pv_wdata = r_q;
				state_d = S_LINK2;
			end
			S_LINK2: begin
				if (r_q != NIL) begin
					wen.nx_we = 1'b1;
					a_waddr = IDX_W'(r_q);
					nx_wdata = LW'(s_q);
				end else begin
					head_d = LW'(s_q);
				end
				if (n_q != NIL) begin
					wen.pv_we = 1'b1;
					b_waddr = IDX_W'(n_q);
					pv_wdata = LW'(s_q);
				end
				flags_d[s_q] = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				done = 1'b1;
				state_d = S_IDLE;
			end
			S_P_RD: begin
				cur_d = head_q;
				oldhead_d = head_q;
				a_raddr = IDX_W'(head_q);
				if (head_q == NIL) begin
					res_status_d = ST_NONE;
					res_slot_d = '0;
					state_d = S_RESULT;
				end else begin
					state_d = S_P_CMP;
				end
			end
			S_P_CMP: begin
				diff = dl_rdata - now_q;
				expired = (diff == '0) || diff[TIME_BITS-1];
				if (expired && cnt_q < CNT_W'(MAX_RESULTS)) begin
					cnt_d = cnt_q + 1'b1;
					cur_d = nx_rdata;
					a_raddr = IDX_W'(nx_rdata);
					if (nx_rdata == NIL) begin
						sleep_d = '0;
						state_d = S_P_FIX;
					end
				end else begin
					sleep_d = expired ? '0 : sat_sleep(diff);
					state_d = S_P_FIX;
				end
			end
			S_P_FIX: begin
				// cur_q is the first entry that stays queued.
				head_d = cur_q;
				if (cur_q != NIL) begin
					wen.pv_we = 1'b1;
					b_waddr = IDX_W'(cur_q);
					pv_wdata = NIL;
				end
				cur_d = oldhead_q;
				k_d = '0;
				if (cnt_q == '0) begin
					res_status_d = ST_NONE;
					res_slot_d = '0;
					state_d = S_RESULT;
				end else begin
					state_d = S_E_RD;
				end
			end
			S_E_RD: begin
				a_raddr = IDX_W'(cur_q);
				state_d = S_E_OUT;
			end
			S_E_OUT: begin
				done = 1'b1;
				out_slot = 6'(cur_q);
				status = ST_EXPIRED;
				last = (k_q == cnt_q - 1'b1);
				flags_d[IDX_W'(cur_q)] = 1'b0;
				cur_d = nx_rdata;
				k_d = k_q + 1'b1;
				state_d = last ? S_IDLE : S_E_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

`ifndef NO_ASSERTIONS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a transaction");
	a_link_unqueued: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LINK2) |-> !flags_q[s_q])
		else $error("inserting a slot that is still queued");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS) || state_q == S_IDLE)
		else $error("poll count beyond result limit");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode != MODE_UNUSED) |=> busy)
		else $error("accepted command did not start work");
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_E_OUT) |-> (cnt_q != '0 && cur_q != NIL))
		else $error("expired report with no popped entry");
`endif

endmodule

@@ sv/dsrq_store.sv @@
module dsrq_store #(
	parameter int SLOTS = 64,
	parameter int TIME_BITS = 32
) (
	input logic clk,
	input dsrq_pkg::dsrq_wen_t wen,
	input logic [$clog2(SLOTS)-1:0] a_waddr,
	input logic [TIME_BITS-1:0] dl_wdata,
	input logic [$clog2(SLOTS+1)-1:0] nx_wdata,
	input logic [$clog2(SLOTS)-1:0] a_raddr,
	output logic [TIME_BITS-1:0] dl_rdata,
	output logic [$clog2(SLOTS+1)-1:0] nx_rdata,
	input logic [$clog2(SLOTS)-1:0] b_waddr,
	input logic [$clog2(SLOTS+1)-1:0] pv_wdata,
	input logic [$clog2(SLOTS)-1:0] b_raddr,
	output logic [$clog2(SLOTS+1)-1:0] pv_rdata
);
	import dsrq_pkg::*;

	localparam int LW = $clog2(SLOTS + 1);

	// Memory A holds deadline and forward link, memory B the backward link.
	logic [TIME_BITS-1:0] dl_mem [SLOTS];
	logic [LW-1:0] nx_mem [SLOTS];
	logic [LW-1:0] pv_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wen.dl_we) begin
			dl_mem[a_waddr] <= dl_wdata;
		end
		if (wen.nx_we) begin
			nx_mem[a_waddr] <= nx_wdata;
		end
		dl_rdata <= dl_mem[a_raddr];
		nx_rdata <= nx_mem[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (wen.pv_we) begin
			pv_mem[b_waddr] <= pv_wdata;
		end
		pv_rdata <= pv_mem[b_raddr];
	end

endmodule

@@ tb/deadline_sorted_request_queue_top_test.sv @@
module deadline_sorted_request_queue_top_test;
	import dsrq_pkg::*;

	// One result as the block reports it.
	typedef struct {
		logic [5:0] slot_id;
		dsrq_status_t stat;
		logic [30:0] sleep;
		logic fin;
	} queue_result_t;

	// Deadline queue predictor and the results that it still owes.
	class deadline_queue_scoreboard;
		localparam int NSLOT = 64;
		localparam int NIL = 64;

		logic [31:0] deadline[NSLOT];
		bit queued[NSLOT];
		int nxt[NSLOT];
		int prv[NSLOT];
		int head;
		queue_result_t owed[$];
		int errors;
		int results_seen;
		int expiries;

		function new();
			for (int i = 0; i < NSLOT; i++) begin
				queued[i] = 0;
				nxt[i] = NIL;
				prv[i] = NIL;
				deadline[i] = '0;
			end
			head = NIL;
			errors = 0;
			results_seen = 0;
			expiries = 0;
		endfunction

		// A deadline counts as reached when deadline minus now is zero or negative.
		function bit reached(logic [31:0] dl, logic [31:0] now);
			logic [31:0] d;
			d = dl - now;
			return d == 0 || d[31];
		endfunction

		function void unlink(int s);
			int p;
			int n;
			p = prv[s];
			n = nxt[s];
			if (p != NIL)
				nxt[p] = n;
			else if (head == s)
				head = n;
			if (n != NIL)
				prv[n] = p;
			prv[s] = NIL;
			nxt[s] = NIL;
			queued[s] = 0;
		endfunction

		function void link(int s);
			logic [31:0] dl;
			logic [31:0] d;
			int r;
			int guard;
			dl = deadline[s];
			d = dl - deadline[head == NIL ? 0 : head];
			if (head == NIL || d[31]) begin
				prv[s] = NIL;
				nxt[s] = head;
				if (head != NIL)
					prv[head] = s;
				head = s;
			end else begin
				r = head;
				guard = 0;
				// Equal deadlines are passed so the new entry goes after them.
				while (nxt[r] != NIL && guard < NSLOT) begin
					d = deadline[nxt[r]] - dl;
					if (d != 0 && !d[31])
						break;
					r = nxt[r];
					guard++;
				end
				nxt[s] = nxt[r];
				prv[s] = r;
				if (nxt[r] != NIL)
					prv[nxt[r]] = s;
				nxt[r] = s;
			end
			queued[s] = 1;
		endfunction

		function void owe(int s, dsrq_status_t st, logic [30:0] sl, bit f);
			queue_result_t r;
			r.slot_id = s[5:0];
			r.stat = st;
			r.sleep = sl;
			r.fin = f;
			owed.push_back(r);
		endfunction

		function void note_command(logic [1:0] md, logic [5:0] sl, logic [30:0] dly,
				logic rs, logic [31:0] now);
			int s;
			int popped[$];
			logic [31:0] d;
			logic [30:0] sleep;
			s = sl;
			if (md == MODE_SCHED) begin
				if (queued[s] && !rs) begin
					owe(s, ST_IGNORED, '0, 1);
				end else begin
					if (queued[s])
						unlink(s);
					deadline[s] = now + {1'b0, dly};
					link(s);
					owe(s, ST_QUEUED, '0, 1);
				end
			end else if (md == MODE_POLL) begin
				while (head != NIL && popped.size() < MAX_RESULTS
						&& reached(deadline[head], now)) begin
					popped.push_back(head);
					unlink(head);
				end
				sleep = '0;
				if (head != NIL && !reached(deadline[head], now)) begin
					d = deadline[head] - now;
					sleep = d > {1'b0, SLEEP_MAX} ? SLEEP_MAX : d[30:0];
				end
				if (popped.size() == 0)
					owe(0, ST_NONE, sleep, 1);
				foreach (popped[k])
					owe(popped[k], ST_EXPIRED, sleep, k == popped.size() - 1);
				expiries += popped.size();
			end else if (md == MODE_CANCEL) begin
				if (queued[s])
					unlink(s);
				owe(s, ST_REMOVED, '0, 1);
			end
		endfunction

		function void check_result(logic [5:0] sl, logic [2:0] st, logic [30:0] slp,
				logic f);
			queue_result_t e;
			results_seen++;
			if (owed.size() == 0) begin
				$error("unexpected result: out_slot %0d status %0d", sl, st);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (sl !== e.slot_id) begin
				$error("out_slot: expected %0d, actual %0d", e.slot_id, sl);
				errors++;
			end
			if (st !== e.stat) begin
				$error("status: expected %0d, actual %0d", e.stat, st);
				errors++;
			end
			if (slp !== e.sleep) begin
				$error("sleep_us: expected %0d, actual %0d", e.sleep, slp);
				errors++;
			end
			if (f !== e.fin) begin
				$error("last: expected %0d, actual %0d", e.fin, f);
				errors++;
			end
		endfunction
	endclass

	// Cycles without any transaction before the run is declared hung. The longest
	// correct poll reports 64 entries, and the sender's random idle gaps are bounded,
	// so this leaves a wide margin.
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 340;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] mode;
	logic [5:0] slot;
	logic [30:0] delay_us;
	logic resync;
	logic [31:0] now_us;
	logic done;
	logic [5:0] out_slot;
	logic [2:0] status;
	logic [30:0] sleep_us;
	logic last;

	deadline_queue_scoreboard sb;
	int accepted;
	int quiet_cycles;
	logic [31:0] clock_us;
	bit allow_gaps;

	deadline_sorted_request_queue_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.slot(slot),
		.delay_us(delay_us),
		.resync(resync),
		.now_us(now_us),
		.done(done),
		.out_slot(out_slot),
		.status(status),
		.sleep_us(sleep_us),
		.last(last)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// The monitor samples at the rising edge. Inputs only move at the falling
	// edge, and the block's outputs still hold the values of the ending cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_command(mode, slot, delay_us, resync, now_us);
				accepted <= accepted + 1;
			end
			if (done)
				sb.check_result(out_slot, status, sleep_us, last);
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Present one command and hold it until the block takes the transaction. The
	// start line stays high afterwards so back-to-back commands need no toggle.
	task automatic issue(logic [1:0] md, logic [5:0] sl, logic [30:0] dly, logic rs,
			logic [31:0] now);
		int seen;
		int gap;
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			start = 0;
			repeat (gap) @(negedge clk);
		end
		mode = md;
		slot = sl;
		delay_us = dly;
		resync = rs;
		now_us = now;
		start = 1;
		seen = accepted;
		do @(negedge clk); while (accepted == seen);
	endtask

	// Hold the sender off until every owed result has been reported.
	task automatic drain();
		start = 0;
		while (sb.owed.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int pick;
		logic [30:0] dly;
		sb = new();
		accepted = 0;
		quiet_cycles = 0;
		allow_gaps = 0;
		start = 0;
		mode = MODE_SCHED;
		slot = '0;
		delay_us = '0;
		resync = 0;
		now_us = '0;
		arst_n = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part. Time starts just below the wrap of the counter, so the
		// first deadlines already straddle it.
		clock_us = 32'hFFFF_FF00;
		issue(MODE_POLL, 0, 0, 0, clock_us);                    // poll of an empty queue
		issue(MODE_CANCEL, 6'd63, 0, 0, clock_us);              // cancel of an idle slot
		issue(MODE_SCHED, 6'd0, 31'd400, 0, clock_us);          // deadline past the wrap
		issue(MODE_SCHED, 6'd63, 31'd100, 0, clock_us);
		issue(MODE_SCHED, 6'd5, 31'd100, 0, clock_us);          // equal deadline goes after
		issue(MODE_SCHED, 6'd7, 31'd0, 0, clock_us);            // zero delay, new head
		issue(MODE_SCHED, 6'd63, 31'd1, 0, clock_us);           // already queued, ignored
		issue(MODE_SCHED, 6'd63, 31'd50, 1, clock_us);          // resync moves it
		issue(MODE_SCHED, 6'd9, 31'h7FFF_FFFF, 0, clock_us);    // largest delay
		issue(MODE_UNUSED, 6'd9, 31'd5, 1, clock_us);           // unused mode, no result
		issue(MODE_POLL, 0, 0, 0, clock_us);                    // only the zero delay expires
		issue(MODE_CANCEL, 6'd5, 0, 0, clock_us);               // cancel in the middle
		issue(MODE_POLL, 0, 0, 0, clock_us + 32'd99);           // only slot 63 expires
		issue(MODE_POLL, 0, 0, 0, clock_us + 32'd100);          // nothing expires, slot 5 was cancelled
		issue(MODE_POLL, 0, 0, 0, clock_us + 32'd1000);
		issue(MODE_CANCEL, 6'd9, 0, 0, clock_us);               // cancel of the head
		issue(MODE_POLL, 0, 0, 0, 32'hFFFF_FFFF);
		drain();

		// Fill every slot with the same deadline and let one poll report all 64.
		clock_us = 32'h8000_0000;
		for (int s = 0; s < 64; s++)
			issue(MODE_SCHED, s[5:0], 31'd10, 0, clock_us);
		issue(MODE_POLL, 0, 0, 0, clock_us + 32'd10);
		drain();

		// Random part: mostly a steadily advancing clock with short delays so the
		// queue holds real chains, with some far deadlines and some time jumps.
		clock_us = $urandom();
		allow_gaps = 1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				drain();
			if (n == RANDOM_ITEMS - 60)
				allow_gaps = 0;
			clock_us = clock_us + $urandom_range(0, 40);
			if ($urandom_range(0, 40) == 0)
				clock_us = $urandom();
			dly = $urandom_range(0, 9) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 300));
			pick = $urandom_range(0, 99);
			if (pick < 50)
				issue(MODE_SCHED, 6'($urandom_range(0, 63)), dly,
					$urandom_range(0, 2) == 0, clock_us);
			else if (pick < 80)
				issue(MODE_POLL, 6'($urandom()), dly, 1'($urandom()), clock_us);
			else if (pick < 96)
				issue(MODE_CANCEL, 6'($urandom_range(0, 63)), dly, 1'($urandom()),
					clock_us);
			else
				issue(MODE_UNUSED, 6'($urandom()), dly, 1'($urandom()), clock_us);
		end
		start = 0;

		// Wait for the owed results, then keep watching for stray ones.
		while (sb.owed.size() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);

		$display("%0d commands accepted, %0d results checked, %0d entries expired",
			accepted, sb.results_seen, sb.expiries);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
